// File: rtl/epvp_pkg.sv
// package for the encoder pi velocity controller: constants, types, helpers and the microcode rom
package epvp_pkg;

    localparam int COUNT_BITS = 16;
    localparam int INTEG_BITS = 48;

    localparam int DELTA_W = COUNT_BITS + 2;
    localparam int MUL_W   = (DELTA_W > 33) ? DELTA_W : 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ILO_W   = INTEG_BITS / 2;
    localparam int ACC_W   = ((INTEG_BITS + 33 > 80) ? INTEG_BITS + 33 : 80) + 2;

    localparam int MEAS_SHIFT = 8;
    localparam int INC_SHIFT  = 8;
    localparam int KP_SHIFT   = 16;
    localparam int DUTY_SHIFT = 40;
    localparam int CMP_SHIFT  = 16;

    localparam int VEL_W  = 32;
    localparam int VAL_W  = 32;
    localparam int GAIN_W = 32;
    localparam int TS_W   = 24;
    localparam int CMP_W  = 17;
    localparam int DUTY_W = 18;
    localparam int CFG_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_VEL_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 3'd4;

    localparam logic [GAIN_W-1:0] VEL_SCALE_RST  = 32'd3294199;
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd2863953;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd145028678;
    localparam logic [TS_W-1:0]   TIME_STEP_RST  = 24'd16777;
    localparam logic [CMP_W-1:0]  PWM_PERIOD_RST = 17'd1000;

    localparam logic signed [DELTA_W-1:0] HALF_D = DELTA_W'(64'd1 << (COUNT_BITS - 1));
    localparam logic signed [DELTA_W-1:0] FULL_D = DELTA_W'(64'd1 << COUNT_BITS);

    localparam logic signed [DUTY_W-1:0] DUTY_POS = 18'sd65536;
    localparam logic signed [DUTY_W-1:0] DUTY_NEG = -18'sd65536;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_VEL,
        MUL_TS,
        MUL_KP,
        MUL_KI_LO,
        MUL_KI_HI,
        MUL_PWM
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MEAS,
        OP_ERR,
        OP_INTEG,
        OP_ACC_KP,
        OP_ACC_LO,
        OP_ACC_HI,
        OP_DUTY,
        OP_OUT
    } op_t;

    typedef enum logic {
        JMP_NEXT,
        JMP_WAIT_OUT
    } jmp_t;

    typedef struct packed {
        mul_sel_t mul;
        op_t      op;
        jmp_t     jmp;
    } ctrl_t;

    // saturate a product-wide signed value to 32 bits
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] vmax;
        logic signed [PROD_W-1:0] vmin;
        vmax = {{(PROD_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        vmin = {{(PROD_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
        if (v > vmax)
            return vmax[VAL_W-1:0];
        else if (v < vmin)
            return vmin[VAL_W-1:0];
        else
            return v[VAL_W-1:0];
    endfunction

    // control program, one word per step
    function automatic ctrl_t uc_rom(input logic [STEP_W-1:0] step);
        ctrl_t c;
        case (step)
            4'd0:    c = '{mul: MUL_VEL,   op: OP_NONE,   jmp: JMP_NEXT};
            4'd1:    c = '{mul: MUL_NONE,  op: OP_MEAS,   jmp: JMP_NEXT};
            4'd2:    c = '{mul: MUL_NONE,  op: OP_ERR,    jmp: JMP_NEXT};
            4'd3:    c = '{mul: MUL_TS,    op: OP_NONE,   jmp: JMP_NEXT};
            4'd4:    c = '{mul: MUL_KP,    op: OP_INTEG,  jmp: JMP_NEXT};
            4'd5:    c = '{mul: MUL_KI_LO, op: OP_ACC_KP, jmp: JMP_NEXT};
            4'd6:    c = '{mul: MUL_KI_HI, op: OP_ACC_LO, jmp: JMP_NEXT};
            4'd7:    c = '{mul: MUL_NONE,  op: OP_ACC_HI, jmp: JMP_NEXT};
            4'd8:    c = '{mul: MUL_NONE,  op: OP_DUTY,   jmp: JMP_NEXT};
            4'd9:    c = '{mul: MUL_PWM,   op: OP_NONE,   jmp: JMP_NEXT};
            4'd10:   c = '{mul: MUL_NONE,  op: OP_OUT,    jmp: JMP_WAIT_OUT};
            default: c = '{mul: MUL_NONE,  op: OP_NONE,   jmp: JMP_WAIT_OUT};
        endcase
        return c;
    endfunction

endpackage

// File: rtl/encoder_pi_velocity_pwm.sv
// encoder pi velocity controller with h-bridge pwm compare outputs
//
// Each request carries an encoder count and a commanded velocity and gives one result:
// measured velocity, speed error, the clamped pi duty and the two bridge compare values.
// A request occupies the block until its program finishes: the accepting cycle latches the count delta,
// then an 11-step microprogram runs and loads the result register in its final step. The steps
// run in sequence since the single shared 33x33 multiplier is used six times in sequence, with a
// result register after it. A new request is taken as soon as the program finishes, even while
// the last result still waits to be taken; the final step holds only while the previous result
// is still held by a stall. Configuration writes take effect at once and are meant for idle
// periods.
module encoder_pi_velocity_pwm
    import epvp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [COUNT_BITS-1:0]       encoder_count,
    input  logic signed [VAL_W-1:0]     target_velocity,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [CMP_W-1:0]            fwd_compare,
    output logic [CMP_W-1:0]            rev_compare,
    output logic signed [DUTY_W-1:0]    duty_out,
    output logic signed [VAL_W-1:0]     measured_velocity,
    output logic signed [VAL_W-1:0]     speed_error
);

    // configuration
    logic [GAIN_W-1:0] vel_scale_reg;
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [TS_W-1:0]   time_step_reg;
    logic [CMP_W-1:0]  pwm_period_reg;

    // sequencer
    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    ctrl_t             ctrl;
    logic              blocked;
    logic              run;
    logic              in_accept;

    // state
    logic [COUNT_BITS-1:0]         last_count_reg;
    logic signed [INTEG_BITS-1:0]  integ_reg, integ_next;

    // datapath
    logic signed [DELTA_W-1:0]  d_raw;
    logic signed [DELTA_W-1:0]  d_reg, d_next;
    logic signed [VAL_W-1:0]    target_reg;
    logic signed [VAL_W-1:0]    meas_reg, meas_next;
    logic signed [VAL_W-1:0]    err_reg, err_next;
    logic signed [MUL_W-1:0]    mul_a, mul_b;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [PROD_W-1:0]   integ_sum;
    logic signed [PROD_W-1:0]   integ_max, integ_min;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    acc_q;
    logic signed [ACC_W-1:0]    acc_pos, acc_neg;
    logic signed [DUTY_W-1:0]   duty_reg, duty_next;
    logic [CMP_W-1:0]           duty_mag;
    logic [CMP_W-1:0]           cmp_val;

    // output register
    logic [CMP_W-1:0]           fwd_reg, rev_reg;
    logic signed [DUTY_W-1:0]   duty_out_reg;
    logic signed [VAL_W-1:0]    meas_out_reg, err_out_reg;

    assign in_accept = in_valid && !busy_reg;
    assign in_stall  = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_scale_reg  <= VEL_SCALE_RST;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            time_step_reg  <= TIME_STEP_RST;
            pwm_period_reg <= PWM_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VEL_SCALE:  vel_scale_reg  <= cfg_data[GAIN_W-1:0];
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_TIME_STEP:  time_step_reg  <= cfg_data[TS_W-1:0];
                CFG_PWM_PERIOD: pwm_period_reg <= cfg_data[CMP_W-1:0];
                default:        ;
            endcase
        end
    end

    // sequencer control
    always_comb
    begin
        ctrl    = uc_rom(step_reg);
        blocked = (ctrl.jmp == JMP_WAIT_OUT) && out_valid_reg && out_stall;
        run     = busy_reg && !blocked;

        busy_next = busy_reg;
        step_next = step_reg;
        if (in_accept)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (run)
        begin
            case (ctrl.jmp)
                JMP_NEXT:
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                JMP_WAIT_OUT:
                begin
                    step_next = '0;
                    busy_next = 1'b0;
                end
                default:
                begin
                    step_next = '0;
                    busy_next = 1'b0;
                end
            endcase
        end

        if (run && ctrl.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // count delta with one rollover unwrapped
    always_comb
    begin
        d_raw = $signed({2'b00, encoder_count}) - $signed({2'b00, last_count_reg});
        if (d_raw < -HALF_D)
            d_next = d_raw + FULL_D;
        else if (d_raw > HALF_D)
            d_next = d_raw - FULL_D;
        else
            d_next = d_raw;
    end

    // shared multiplier operand select
    always_comb
    begin
        duty_mag = duty_reg[DUTY_W-1] ? CMP_W'(-duty_reg) : duty_reg[CMP_W-1:0];
        mul_a = '0;
        mul_b = '0;
        case (run ? ctrl.mul : MUL_NONE)
            MUL_VEL:
            begin
                mul_a = MUL_W'(d_reg);
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, vel_scale_reg};
            end
            MUL_TS:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = {{(MUL_W-TS_W){1'b0}}, time_step_reg};
            end
            MUL_KP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, prop_gain_reg};
            end
            MUL_KI_LO:
            begin
                mul_a = {{(MUL_W-ILO_W){1'b0}}, integ_reg[ILO_W-1:0]};
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, integ_gain_reg};
            end
            MUL_KI_HI:
            begin
                mul_a = MUL_W'($signed(integ_reg[INTEG_BITS-1:ILO_W]));
                mul_b = {{(MUL_W-GAIN_W){1'b0}}, integ_gain_reg};
            end
            MUL_PWM:
            begin
                mul_a = {{(MUL_W-CMP_W){1'b0}}, pwm_period_reg};
                mul_b = {{(MUL_W-CMP_W){1'b0}}, duty_mag};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // datapath write-back
    always_comb
    begin
        meas_next  = sat32(prod_reg >>> MEAS_SHIFT);
        err_next   = sat32(PROD_W'(target_reg) - PROD_W'(meas_reg));

        integ_max  = {{(PROD_W-INTEG_BITS+1){1'b0}}, {(INTEG_BITS-1){1'b1}}};
        integ_min  = {{(PROD_W-INTEG_BITS+1){1'b1}}, {(INTEG_BITS-1){1'b0}}};
        integ_sum  = PROD_W'(integ_reg) + (prod_reg >>> INC_SHIFT);
        if (integ_sum > integ_max)
            integ_next = integ_max[INTEG_BITS-1:0];
        else if (integ_sum < integ_min)
            integ_next = integ_min[INTEG_BITS-1:0];
        else
            integ_next = integ_sum[INTEG_BITS-1:0];

        acc_next = acc_reg;
        case (ctrl.op)
            OP_ACC_KP: acc_next = ACC_W'(prod_reg) <<< KP_SHIFT;
            OP_ACC_LO: acc_next = acc_reg + ACC_W'(prod_reg);
            OP_ACC_HI: acc_next = acc_reg + (ACC_W'(prod_reg) <<< ILO_W);
            default:   acc_next = acc_reg;
        endcase

        acc_q   = acc_reg >>> DUTY_SHIFT;
        acc_pos = ACC_W'(DUTY_POS);
        acc_neg = ACC_W'(DUTY_NEG);
        if (acc_q > acc_pos)
            duty_next = DUTY_POS;
        else if (acc_q < acc_neg)
            duty_next = DUTY_NEG;
        else
            duty_next = acc_q[DUTY_W-1:0];

        cmp_val = prod_reg[CMP_W+CMP_SHIFT-1:CMP_SHIFT];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            last_count_reg <= '0;
            integ_reg      <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
                last_count_reg <= encoder_count;
            if (run && ctrl.op == OP_INTEG)
                integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            d_reg      <= d_next;
            target_reg <= target_velocity;
        end
        if (run && ctrl.mul != MUL_NONE)
            prod_reg <= prod_next;
        if (run && ctrl.op == OP_MEAS)
            meas_reg <= meas_next;
        if (run && ctrl.op == OP_ERR)
            err_reg <= err_next;
        if (run)
            acc_reg <= acc_next;
        if (run && ctrl.op == OP_DUTY)
            duty_reg <= duty_next;
        if (run && ctrl.op == OP_OUT)
        begin
            fwd_reg      <= duty_reg[DUTY_W-1] ? '0 : cmp_val;
            rev_reg      <= duty_reg[DUTY_W-1] ? cmp_val : '0;
            duty_out_reg <= duty_reg;
            meas_out_reg <= meas_reg;
            err_out_reg  <= err_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign fwd_compare       = fwd_reg;
    assign rev_compare       = rev_reg;
    assign duty_out          = duty_out_reg;
    assign measured_velocity = meas_out_reg;
    assign speed_error       = err_out_reg;

endmodule
